FILE: sv/vn3_pkg.sv
// vn3_pkg: shared types and hash constants for the 3-d value noise pipeline
// no dependencies; imported by every module of value_noise_3d
package vn3_pkg;

  // fixed-point formats
  localparam int Q24_W   = 24;
  localparam int AXES    = 3;
  localparam int CORNERS = 8;

  // axis positions in the coordinate vectors
  localparam int AX_X = 0;
  localparam int AX_Z = 1;
  localparam int AX_T = 2;

  typedef logic [31:0]      word_t;
  typedef logic [Q24_W-1:0] q24_t;

  // hash multipliers
  localparam word_t LANE_MUL = 32'h9e3779b9;
  localparam word_t X_MUL    = 32'h85ebca6b;
  localparam word_t Z_MUL    = 32'hc2b2ae35;
  localparam word_t T_MUL    = 32'h27d4eb2f;
  localparam word_t MIX1_MUL = 32'h7feb352d;
  localparam word_t MIX2_MUL = 32'h846ca68b;

  // 3.0 in Q2.24 for the smoothstep weight
  localparam logic [Q24_W+1:0] THREE_Q24 = 26'd50331648;

  // per-axis hash multiplier
  function automatic word_t axis_mul(input int axis);
    word_t m;
    case (axis)
      AX_X:    m = X_MUL;
      AX_Z:    m = Z_MUL;
      AX_T:    m = T_MUL;
      default: m = X_MUL;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/vn3_lattice.sv
// vn3_lattice: splits each coordinate into lattice index and Q0.24 fraction
// and folds both neighboring 64-bit indexes to 32 bits; uses vn3_pkg
module vn3_lattice import vn3_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic [AXES-1:0][INT_BITS+FRAC_BITS-1:0] coord,
  input  word_t                                   in_lane,
  output logic                                    out_valid,
  output word_t                                   out_lane,
  output word_t [1:0][AXES-1:0]                   fold,
  output q24_t  [AXES-1:0]                        frac
);

  logic                   valid_r;
  word_t                  lane_r;
  word_t [1:0][AXES-1:0]  fold_r, fold_nxt;
  q24_t  [AXES-1:0]       frac_r, frac_nxt;
  logic  [AXES-1:0][INT_BITS-1:0] ipart;
  logic  [AXES-1:0][63:0] idx0, idx1;

  // floor index, its +1 neighbor in 64 bits, folds and fractions
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ipart[a]       = coord[a][INT_BITS+FRAC_BITS-1:FRAC_BITS];
      idx0[a]        = {{(64-INT_BITS){ipart[a][INT_BITS-1]}}, ipart[a]};
      idx1[a]        = idx0[a] + 64'd1;
      fold_nxt[0][a] = idx0[a][31:0] ^ idx0[a][63:32];
      fold_nxt[1][a] = idx1[a][31:0] ^ idx1[a][63:32];
      frac_nxt[a]    = Q24_W'(coord[a][FRAC_BITS-1:0]) << (Q24_W - FRAC_BITS);
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    lane_r <= in_lane;
    fold_r <= fold_nxt;
    frac_r <= frac_nxt;
  end

  assign out_valid = valid_r;
  assign out_lane  = lane_r;
  assign fold      = fold_r;
  assign frac      = frac_r;

endmodule

FILE: sv/vn3_hash.sv
// vn3_hash: four-stage corner hash for the eight lattice corners
// (axis multiply, seed combine and first mix, second mix, final xor-shift)
// uses vn3_pkg
module vn3_hash import vn3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  word_t                 seed,
  input  word_t                 lane,
  input  word_t [1:0][AXES-1:0] fold,
  output logic                  out_valid,
  output q24_t  [CORNERS-1:0]   corner
);

  logic                  v2_r, v3_r, v4_r, v5_r;
  word_t                 lane_p_r, lane_p_nxt;
  word_t [1:0][AXES-1:0] prod_r, prod_nxt;
  word_t [CORNERS-1:0]   h3, m1_r, m1_nxt;
  word_t [CORNERS-1:0]   h4, m2_r, m2_nxt;
  word_t [CORNERS-1:0]   h5;
  q24_t  [CORNERS-1:0]   corner_r, corner_nxt;

  // axis and lane products
  always_comb begin
    lane_p_nxt = word_t'(lane * LANE_MUL);
    for (int o = 0; o < 2; o++) begin
      for (int a = 0; a < AXES; a++) begin
        prod_nxt[o][a] = word_t'(fold[o][a] * axis_mul(a));
      end
    end
  end

  // per-corner combine and first avalanche multiply
  always_comb begin
    for (int c = 0; c < CORNERS; c++) begin
      h3[c] = seed ^ lane_p_r ^ prod_r[c[0]][AX_X] ^ prod_r[c[1]][AX_Z]
            ^ prod_r[c[2]][AX_T];
      h3[c] = h3[c] ^ (h3[c] >> 16);
      m1_nxt[c] = word_t'(h3[c] * MIX1_MUL);
    end
  end

  // second avalanche multiply
  always_comb begin
    for (int c = 0; c < CORNERS; c++) begin
      h4[c]     = m1_r[c] ^ (m1_r[c] >> 15);
      m2_nxt[c] = word_t'(h4[c] * MIX2_MUL);
    end
  end

  // final xor-shift, keep 24 bits
  always_comb begin
    for (int c = 0; c < CORNERS; c++) begin
      h5[c]         = m2_r[c] ^ (m2_r[c] >> 16);
      corner_nxt[c] = h5[c][Q24_W-1:0];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v2_r <= in_valid;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    lane_p_r <= lane_p_nxt;
    prod_r   <= prod_nxt;
    m1_r     <= m1_nxt;
    m2_r     <= m2_nxt;
    corner_r <= corner_nxt;
  end

  assign out_valid = v5_r;
  assign corner    = corner_r;

endmodule

FILE: sv/vn3_smooth.sv
// vn3_smooth: two-stage smoothstep of the three Q0.24 fractions
// stage one squares, stage two applies the 3 - 2f weight; uses vn3_pkg
module vn3_smooth import vn3_pkg::*; (
  input  logic             clk,
  input  q24_t [AXES-1:0]  frac,
  output q24_t [AXES-1:0]  smooth
);

  q24_t [AXES-1:0]        f_r;
  q24_t [AXES-1:0]        sq_r, sq_nxt;
  q24_t [AXES-1:0]        s_r, s_nxt;
  logic [AXES-1:0][47:0]  ff;
  logic [AXES-1:0][Q24_W+1:0] wgt;
  logic [AXES-1:0][49:0]  sw;

  // f squared, truncated to Q0.24
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ff[a]     = 48'(frac[a]) * 48'(frac[a]);
      sq_nxt[a] = ff[a][47:24];
    end
  end

  // times (3 - 2f), truncated to Q0.24
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      wgt[a]   = THREE_Q24 - {1'b0, f_r[a], 1'b0};
      sw[a]    = 50'(sq_r[a]) * 50'(wgt[a]);
      s_nxt[a] = sw[a][47:24];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    f_r  <= frac;
    sq_r <= sq_nxt;
    s_r  <= s_nxt;
  end

  assign smooth = s_r;

endmodule

FILE: sv/vn3_blend.sv
// vn3_blend: three-stage linear blend of LANES value pairs with one weight
// (difference, scaled step, add back); uses vn3_pkg
module vn3_blend import vn3_pkg::*; #(
  parameter int LANES = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  q24_t [2*LANES-1:0]     pair,
  input  q24_t                   weight,
  output logic                   out_valid,
  output q24_t [LANES-1:0]       mixed
);

  logic                  v1_r, v2_r, v3_r;
  q24_t                  w_r;
  logic [LANES-1:0]      down1_r, down1_nxt, down2_r;
  q24_t [LANES-1:0]      base1_r, base2_r;
  q24_t [LANES-1:0]      diff_r, diff_nxt;
  q24_t [LANES-1:0]      step_r, step_nxt;
  q24_t [LANES-1:0]      mixed_r, mixed_nxt;
  logic [LANES-1:0][47:0] scaled;

  // magnitude and direction of b - a
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      down1_nxt[l] = pair[2*l+1] < pair[2*l];
      diff_nxt[l]  = down1_nxt[l] ? (pair[2*l] - pair[2*l+1])
                                  : (pair[2*l+1] - pair[2*l]);
    end
  end

  // step = |b - a| * t, truncated
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      scaled[l]   = 48'(diff_r[l]) * 48'(w_r);
      step_nxt[l] = scaled[l][47:24];
    end
  end

  // move from a toward b
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mixed_nxt[l] = down2_r[l] ? (base2_r[l] - step_r[l]) : (base2_r[l] + step_r[l]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      base1_r[l] <= pair[2*l];
    end
    w_r     <= weight;
    down1_r <= down1_nxt;
    diff_r  <= diff_nxt;
    base2_r <= base1_r;
    down2_r <= down1_r;
    step_r  <= step_nxt;
    mixed_r <= mixed_nxt;
  end

  assign out_valid = v3_r;
  assign mixed     = mixed_r;

  // the lane-0 blended value never leaves the span of its two inputs
  a_blend_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> ((mixed_r[0] >= $past(pair[0], 3) && mixed_r[0] <= $past(pair[1], 3)) ||
              (mixed_r[0] <= $past(pair[0], 3) && mixed_r[0] >= $past(pair[1], 3))))
    else $error("blend result outside its input span");

endmodule

FILE: sv/value_noise_3d.sv
// value_noise_3d: top level of the pipelined 3-d value noise generator
// depends on vn3_pkg, vn3_lattice, vn3_hash, vn3_smooth, vn3_blend
//
// usage
//   input: drive start with a point (in_coord_x, in_coord_z, in_time_pos)
//   and a lane tag; the transfer happens at a clock edge with start high and
//   busy low. busy is high only during reset and in the cycle after it, so one point can
//   enter every cycle.
//   output: out_valid strobes for one cycle with out_noise_value (Q0.24).
//   Each point passes through 1 lattice stage, 4 hash stages and three
//   3-stage blend levels (the smoothstep runs alongside the hash).
//   Throughput is one point per cycle; results leave in input order.
//   config: cfg_data is written to the seed when cfg_valid is high (cfg_ready
//   is always high); write it only while no point is in flight.
//   reset: synchronous, active low; clears the seed to 0 and empties the
//   pipeline. The receiver cannot stall, so results are never held back.
module value_noise_3d import vn3_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] in_coord_x,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] in_coord_z,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] in_time_pos,
  input  logic [31:0]                         in_noise_lane,
  output logic                                out_valid,
  output logic [Q24_W-1:0]                    out_noise_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [31:0]                         cfg_data
);

  localparam int COORD_W = INT_BITS + FRAC_BITS;
  // smoothed weights wait for the hash and for earlier blend levels
  localparam int SX_DLY  = 2;
  localparam int SZ_DLY  = 5;
  localparam int ST_DLY  = 8;

  logic                        busy_r;
  word_t                       seed_r;
  logic                        accept;
  logic [AXES-1:0][COORD_W-1:0] coord;
  logic                        lat_valid, hash_valid, lvl1_valid, lvl2_valid, lvl3_valid;
  word_t                       lat_lane;
  word_t [1:0][AXES-1:0]       fold;
  q24_t  [AXES-1:0]            frac, smooth;
  q24_t  [CORNERS-1:0]         corner;
  q24_t  [3:0]                 lvl1;
  q24_t  [1:0]                 lvl2;
  q24_t  [0:0]                 lvl3;
  q24_t                        sx_dly_r [SX_DLY];
  q24_t                        sz_dly_r [SZ_DLY];
  q24_t                        st_dly_r [ST_DLY];

  // input transfer
  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // busy only while coming out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // seed register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_data;
    end
  end

  // coordinate vector
  assign coord[AX_X] = in_coord_x;
  assign coord[AX_Z] = in_coord_z;
  assign coord[AX_T] = in_time_pos;

  // lattice split
  vn3_lattice #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_lattice (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .coord     (coord),
    .in_lane   (in_noise_lane),
    .out_valid (lat_valid),
    .out_lane  (lat_lane),
    .fold      (fold),
    .frac      (frac)
  );

  // corner hashes
  vn3_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lat_valid),
    .seed      (seed_r),
    .lane      (lat_lane),
    .fold      (fold),
    .out_valid (hash_valid),
    .corner    (corner)
  );

  // smoothstep weights
  vn3_smooth u_smooth (
    .clk    (clk),
    .frac   (frac),
    .smooth (smooth)
  );

  // weight delay lines
  always_ff @(posedge clk) begin
    sx_dly_r[0] <= smooth[AX_X];
    for (int i = 1; i < SX_DLY; i++) begin
      sx_dly_r[i] <= sx_dly_r[i-1];
    end
    sz_dly_r[0] <= smooth[AX_Z];
    for (int i = 1; i < SZ_DLY; i++) begin
      sz_dly_r[i] <= sz_dly_r[i-1];
    end
    st_dly_r[0] <= smooth[AX_T];
    for (int i = 1; i < ST_DLY; i++) begin
      st_dly_r[i] <= st_dly_r[i-1];
    end
  end

  // blend along x
  vn3_blend #(.LANES(4)) u_blend_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hash_valid),
    .pair      (corner),
    .weight    (sx_dly_r[SX_DLY-1]),
    .out_valid (lvl1_valid),
    .mixed     (lvl1)
  );

  // blend along z
  vn3_blend #(.LANES(2)) u_blend_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lvl1_valid),
    .pair      (lvl1),
    .weight    (sz_dly_r[SZ_DLY-1]),
    .out_valid (lvl2_valid),
    .mixed     (lvl2)
  );

  // blend along time
  vn3_blend #(.LANES(1)) u_blend_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lvl2_valid),
    .pair      (lvl2),
    .weight    (st_dly_r[ST_DLY-1]),
    .out_valid (lvl3_valid),
    .mixed     (lvl3)
  );

  assign out_valid       = lvl3_valid;
  assign out_noise_value = lvl3[0];

  // every result comes from an earlier input transfer
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 14))
    else $error("result strobe without a matching input transfer");

  // busy clears in the cycle after reset is released
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset recovery");

endmodule
